// ===== rtl/tked_pkg.sv =====
package tked_pkg;

    // Position within an escape sequence.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ESC   = 3'd1,
        PH_CSI   = 3'd2,
        PH_NUM   = 3'd3,
        PH_SEMI  = 3'd4,
        PH_FINAL = 3'd5,
        PH_SS3   = 3'd6
    } phase_t;

    typedef struct packed {
        logic       byte_present;
        logic [7:0] in_byte;
    } poll_t;

    typedef struct packed {
        logic       valid;
        logic       is_key;
        logic [7:0] value;
    } result_t;

    localparam int unsigned ACC_W = 7;
    localparam logic [ACC_W-1:0] ACC_MAX = 7'd99;

    localparam logic [7:0] KEY_ESC     = 8'd0;
    localparam logic [7:0] KEY_ENTER   = 8'd1;
    localparam logic [7:0] KEY_TAB     = 8'd2;
    localparam logic [7:0] KEY_BKSP    = 8'd3;
    localparam logic [7:0] KEY_UP      = 8'd4;
    localparam logic [7:0] KEY_DOWN    = 8'd5;
    localparam logic [7:0] KEY_RIGHT   = 8'd6;
    localparam logic [7:0] KEY_LEFT    = 8'd7;
    localparam logic [7:0] KEY_HOME    = 8'd8;
    localparam logic [7:0] KEY_END     = 8'd9;
    localparam logic [7:0] KEY_INS     = 8'd10;
    localparam logic [7:0] KEY_DEL     = 8'd11;
    localparam logic [7:0] KEY_PGUP    = 8'd12;
    localparam logic [7:0] KEY_PGDN    = 8'd13;
    localparam logic [7:0] KEY_F1      = 8'd14;
    localparam logic [7:0] KEY_F2      = 8'd15;
    localparam logic [7:0] KEY_F3      = 8'd16;
    localparam logic [7:0] KEY_F4      = 8'd17;
    localparam logic [7:0] KEY_F5      = 8'd18;
    localparam logic [7:0] KEY_F6      = 8'd19;
    localparam logic [7:0] KEY_F7      = 8'd20;
    localparam logic [7:0] KEY_F8      = 8'd21;
    localparam logic [7:0] KEY_F9      = 8'd22;
    localparam logic [7:0] KEY_F10     = 8'd23;
    localparam logic [7:0] KEY_F11     = 8'd24;
    localparam logic [7:0] KEY_F12     = 8'd25;
    localparam logic [7:0] KEY_BACKTAB = 8'd26;
    localparam logic [7:0] KEY_NONE    = 8'd255;

    localparam logic [7:0] CH_BS     = 8'd8;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_ESC    = 8'd27;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SS3    = 8'h4F;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_Q      = 8'h51;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_Z      = 8'h5A;

    function automatic logic [7:0] tilde_key(input logic [ACC_W-1:0] n);
        logic [7:0] k;
        begin
            unique case (n)
                7'd1:    k = KEY_HOME;
                7'd2:    k = KEY_INS;
                7'd3:    k = KEY_DEL;
                7'd4:    k = KEY_END;
                7'd5:    k = KEY_PGUP;
                7'd6:    k = KEY_PGDN;
                7'd7:    k = KEY_HOME;
                7'd8:    k = KEY_END;
                7'd11:   k = KEY_F1;
                7'd12:   k = KEY_F2;
                7'd13:   k = KEY_F3;
                7'd14:   k = KEY_F4;
                7'd15:   k = KEY_F5;
                7'd17:   k = KEY_F6;
                7'd18:   k = KEY_F7;
                7'd19:   k = KEY_F8;
                7'd20:   k = KEY_F9;
                7'd21:   k = KEY_F10;
                7'd23:   k = KEY_F11;
                7'd24:   k = KEY_F12;
                default: k = KEY_NONE;
            endcase
            return k;
        end
    endfunction

    function automatic logic [7:0] csi_letter(input logic [7:0] c);
        logic [7:0] k;
        begin
            unique case (c)
                CH_A:    k = KEY_UP;
                CH_B:    k = KEY_DOWN;
                CH_C:    k = KEY_RIGHT;
                CH_D:    k = KEY_LEFT;
                CH_H:    k = KEY_HOME;
                CH_F:    k = KEY_END;
                CH_Z:    k = KEY_BACKTAB;
                default: k = KEY_NONE;
            endcase
            return k;
        end
    endfunction

    function automatic logic [7:0] ss3_letter(input logic [7:0] c);
        logic [7:0] k;
        begin
            unique case (c)
                CH_P:    k = KEY_F1;
                CH_Q:    k = KEY_F2;
                CH_R:    k = KEY_F3;
                CH_S:    k = KEY_F4;
                CH_H:    k = KEY_HOME;
                CH_F:    k = KEY_END;
                default: k = KEY_NONE;
            endcase
            return k;
        end
    endfunction

endpackage

// ===== rtl/tked_if.sv =====
interface tked_poll_if;
    logic       valid;
    logic       ready;
    logic       byte_present;
    logic [7:0] in_byte;

    modport source (output valid, output byte_present, output in_byte, input ready);
    modport sink (input valid, input byte_present, input in_byte, output ready);
endinterface

interface tked_result_if;
    logic       valid;
    logic       ready;
    logic       is_key;
    logic [7:0] value;

    modport source (output valid, output is_key, output value, input ready);
    modport sink (input valid, input is_key, input value, output ready);
endinterface

// ===== rtl/tked_in_stage.sv =====
module tked_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    tked_poll_if.sink         poll,
    input  logic              can_take,
    output tked_pkg::poll_t   item,
    output logic              fire
);

    logic             valid_reg;
    tked_pkg::poll_t  item_reg;
    logic             load;

    // The held poll moves on whenever the result side has room.
    assign fire       = valid_reg && can_take;
    assign poll.ready = !valid_reg || fire;
    assign load       = poll.valid && poll.ready;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            valid_reg <= poll.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.byte_present <= poll.byte_present;
            item_reg.in_byte      <= poll.in_byte;
        end
    end

endmodule

// ===== rtl/tked_decode.sv =====
module tked_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  tked_pkg::poll_t     item,
    input  logic                fire,
    output tked_pkg::result_t   res
);

    tked_pkg::phase_t              phase_reg, phase_next;
    logic [tked_pkg::ACC_W-1:0]    num_reg, num_next;

    logic       have;
    logic [7:0] c;
    logic       digit;
    logic [9:0] acc_sum;
    logic [7:0] key;
    logic       pass;

    assign have    = item.byte_present;
    assign c       = item.in_byte;
    assign digit   = have && (c >= tked_pkg::CH_ZERO) && (c <= tked_pkg::CH_NINE);
    // For an ASCII digit the low nibble is its value.
    assign acc_sum = 10'(num_reg) * 10'd10 + 10'(c[3:0]);

    always_comb
    begin
        phase_next = phase_reg;
        num_next   = num_reg;
        key        = tked_pkg::KEY_NONE;
        pass       = 1'b0;
        if (fire)
        begin
            unique case (phase_reg)
                tked_pkg::PH_ESC:
                begin
                    phase_next = tked_pkg::PH_IDLE;
                    if (!have)
                    begin
                        key = tked_pkg::KEY_ESC;
                    end
                    else if (c == tked_pkg::CH_LBRACK)
                    begin
                        phase_next = tked_pkg::PH_CSI;
                    end
                    else if (c == tked_pkg::CH_SS3)
                    begin
                        phase_next = tked_pkg::PH_SS3;
                    end
                end
                tked_pkg::PH_CSI:
                begin
                    phase_next = tked_pkg::PH_IDLE;
                    if (!have)
                    begin
                        key = tked_pkg::KEY_ESC;
                    end
                    else if (digit)
                    begin
                        num_next   = {3'd0, c[3:0]};
                        phase_next = tked_pkg::PH_NUM;
                    end
                    else
                    begin
                        key = tked_pkg::csi_letter(c);
                    end
                end
                tked_pkg::PH_NUM:
                begin
                    if (digit)
                    begin
                        num_next = (acc_sum > 10'(tked_pkg::ACC_MAX)) ?
                                   tked_pkg::ACC_MAX : acc_sum[tked_pkg::ACC_W-1:0];
                    end
                    else if (have && c == tked_pkg::CH_SEMI)
                    begin
                        phase_next = tked_pkg::PH_SEMI;
                    end
                    else
                    begin
                        phase_next = tked_pkg::PH_IDLE;
                        if (have && c == tked_pkg::CH_TILDE)
                        begin
                            key = tked_pkg::tilde_key(num_reg);
                        end
                    end
                end
                tked_pkg::PH_SEMI:
                begin
                    // The modifier is consumed whatever it is.
                    phase_next = tked_pkg::PH_FINAL;
                end
                tked_pkg::PH_FINAL:
                begin
                    phase_next = tked_pkg::PH_IDLE;
                    if (have && c == tked_pkg::CH_Z)
                    begin
                        key = tked_pkg::KEY_BACKTAB;
                    end
                end
                tked_pkg::PH_SS3:
                begin
                    phase_next = tked_pkg::PH_IDLE;
                    if (!have)
                    begin
                        key = tked_pkg::KEY_ESC;
                    end
                    else
                    begin
                        key = tked_pkg::ss3_letter(c);
                    end
                end
                default:
                begin
                    phase_next = tked_pkg::PH_IDLE;
                    if (have)
                    begin
                        if (c == tked_pkg::CH_ESC)
                        begin
                            phase_next = tked_pkg::PH_ESC;
                        end
                        else if (c == tked_pkg::CH_CR || c == tked_pkg::CH_LF)
                        begin
                            key = tked_pkg::KEY_ENTER;
                        end
                        else if (c == tked_pkg::CH_TAB)
                        begin
                            key = tked_pkg::KEY_TAB;
                        end
                        else if (c == tked_pkg::CH_DEL || c == tked_pkg::CH_BS)
                        begin
                            key = tked_pkg::KEY_BKSP;
                        end
                        else
                        begin
                            pass = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res.valid  = pass || (key != tked_pkg::KEY_NONE);
        res.is_key = !pass;
        res.value  = pass ? c : key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tked_pkg::PH_IDLE;
            num_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            num_reg   <= num_next;
        end
    end

endmodule

// ===== rtl/tked_out_stage.sv =====
module tked_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  tked_pkg::result_t   res,
    output logic                can_take,
    tked_result_if.source       result
);

    logic             main_valid_reg;
    logic             main_is_key_reg;
    logic [7:0]       main_value_reg;
    logic             skid_valid_reg;
    logic             skid_is_key_reg;
    logic [7:0]       skid_value_reg;
    logic             main_free;

    // The skid entry catches a result that lands while the output is stalled.
    assign can_take  = !skid_valid_reg;
    assign main_free = !main_valid_reg || result.ready;

    assign result.valid  = main_valid_reg;
    assign result.is_key = main_is_key_reg;
    assign result.value  = main_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (main_free)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (main_free)
        begin
            main_valid_reg <= res.valid;
        end
        else if (res.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (main_free)
            begin
                main_is_key_reg <= skid_is_key_reg;
                main_value_reg  <= skid_value_reg;
            end
        end
        else if (main_free)
        begin
            main_is_key_reg <= res.is_key;
            main_value_reg  <= res.value;
        end
        else if (res.valid)
        begin
            skid_is_key_reg <= res.is_key;
            skid_value_reg  <= res.value;
        end
    end

endmodule

// ===== rtl/terminal_key_escape_decoder_top.sv =====
// A poll taken into the input register is decoded combinationally; its result is
// offered once registered in the output register, unless the output is stalled.
// Throughput: one poll per cycle unless stalled; the input register, the decoder's
// phase and accumulator registers and the two-entry output register all advance
// together. Reset (rst_n, asynchronous, active low) empties both registers and
// returns the decoder to idle with the digit accumulator at zero.
module terminal_key_escape_decoder_top (
    input  logic            clk,
    input  logic            rst_n,
    tked_poll_if.sink       poll,
    tked_result_if.source   result
);

    tked_pkg::poll_t    item;
    tked_pkg::result_t  res;
    logic               fire;
    logic               can_take;

    tked_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .poll     (poll),
        .can_take (can_take),
        .item     (item),
        .fire     (fire)
    );

    tked_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .fire  (fire),
        .res   (res)
    );

    tked_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .can_take (can_take),
        .result   (result)
    );

endmodule

// ===== tb/terminal_key_escape_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module terminal_key_escape_decoder_top_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        logic       is_key;
        logic [7:0] value;
    } key_event_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tked_poll_if   poll_ch();
    tked_result_if result_ch();

    terminal_key_escape_decoder_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_ch),
        .result (result_ch)
    );

    tked_pkg::phase_t seq_phase    = tked_pkg::PH_IDLE;
    logic [6:0] digit_accum    = '0;
    key_event_t pending_keys[$];
    int         error_count    = 0;
    int         cycle_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         polls_sent     = 0;

    always #5 clk = ~clk;

    // Key selected by the number in front of a tilde.
    function automatic logic [7:0] number_key(input logic [6:0] n);
        logic [7:0] k;
        k = tked_pkg::KEY_NONE;
        if (n == 7'd1 || n == 7'd7)
            k = tked_pkg::KEY_HOME;
        else if (n == 7'd4 || n == 7'd8)
            k = tked_pkg::KEY_END;
        else if (n == 7'd2)
            k = tked_pkg::KEY_INS;
        else if (n == 7'd3)
            k = tked_pkg::KEY_DEL;
        else if (n == 7'd5)
            k = tked_pkg::KEY_PGUP;
        else if (n == 7'd6)
            k = tked_pkg::KEY_PGDN;
        else if (n >= 7'd11 && n <= 7'd15)
            k = tked_pkg::KEY_F1 + {1'b0, n} - 8'd11;
        else if (n >= 7'd17 && n <= 7'd21)
            k = tked_pkg::KEY_F6 + {1'b0, n} - 8'd17;
        else if (n == 7'd23 || n == 7'd24)
            k = tked_pkg::KEY_F11 + {1'b0, n} - 8'd23;
        return k;
    endfunction

    function automatic logic [7:0] csi_final_key(input logic [7:0] c);
        case (c)
            tked_pkg::CH_A:    return tked_pkg::KEY_UP;
            tked_pkg::CH_B:    return tked_pkg::KEY_DOWN;
            tked_pkg::CH_C:    return tked_pkg::KEY_RIGHT;
            tked_pkg::CH_D:    return tked_pkg::KEY_LEFT;
            tked_pkg::CH_H:    return tked_pkg::KEY_HOME;
            tked_pkg::CH_F:    return tked_pkg::KEY_END;
            tked_pkg::CH_Z:    return tked_pkg::KEY_BACKTAB;
            default:           return tked_pkg::KEY_NONE;
        endcase
    endfunction

    function automatic logic [7:0] ss3_final_key(input logic [7:0] c);
        case (c)
            tked_pkg::CH_P:    return tked_pkg::KEY_F1;
            tked_pkg::CH_Q:    return tked_pkg::KEY_F2;
            tked_pkg::CH_R:    return tked_pkg::KEY_F3;
            tked_pkg::CH_S:    return tked_pkg::KEY_F4;
            tked_pkg::CH_H:    return tked_pkg::KEY_HOME;
            tked_pkg::CH_F:    return tked_pkg::KEY_END;
            default:           return tked_pkg::KEY_NONE;
        endcase
    endfunction

    // Advances the sequence state by one poll and queues the key or raw byte it produces.
    function automatic void decode_poll(input logic present, input logic [7:0] ch);
        logic [7:0] key;
        logic       raw;
        logic       is_digit;
        int         grown;
        key_event_t ev;
        key = tked_pkg::KEY_NONE;
        raw = 1'b0;
        is_digit = present && ch >= tked_pkg::CH_ZERO && ch <= tked_pkg::CH_NINE;
        case (seq_phase)
            tked_pkg::PH_ESC:
            begin
                seq_phase = tked_pkg::PH_IDLE;
                if (!present)
                    key = tked_pkg::KEY_ESC;
                else if (ch == tked_pkg::CH_LBRACK)
                    seq_phase = tked_pkg::PH_CSI;
                else if (ch == tked_pkg::CH_SS3)
                    seq_phase = tked_pkg::PH_SS3;
            end
            tked_pkg::PH_CSI:
            begin
                seq_phase = tked_pkg::PH_IDLE;
                if (!present)
                    key = tked_pkg::KEY_ESC;
                else if (is_digit)
                begin
                    digit_accum = 7'(ch - tked_pkg::CH_ZERO);
                    seq_phase = tked_pkg::PH_NUM;
                end
                else
                    key = csi_final_key(ch);
            end
            tked_pkg::PH_NUM:
            begin
                if (is_digit)
                begin
                    grown = int'(digit_accum) * 10 + int'(ch - tked_pkg::CH_ZERO);
                    digit_accum = (grown > int'(tked_pkg::ACC_MAX)) ?
                                  tked_pkg::ACC_MAX : 7'(grown);
                end
                else if (present && ch == tked_pkg::CH_SEMI)
                    seq_phase = tked_pkg::PH_SEMI;
                else
                begin
                    seq_phase = tked_pkg::PH_IDLE;
                    if (present && ch == tked_pkg::CH_TILDE)
                        key = number_key(digit_accum);
                end
            end
            tked_pkg::PH_SEMI:
                seq_phase = tked_pkg::PH_FINAL;
            tked_pkg::PH_FINAL:
            begin
                seq_phase = tked_pkg::PH_IDLE;
                if (present && ch == tked_pkg::CH_Z)
                    key = tked_pkg::KEY_BACKTAB;
            end
            tked_pkg::PH_SS3:
            begin
                seq_phase = tked_pkg::PH_IDLE;
                key = present ? ss3_final_key(ch) : tked_pkg::KEY_ESC;
            end
            default:
            begin
                seq_phase = tked_pkg::PH_IDLE;
                if (present)
                begin
                    if (ch == tked_pkg::CH_ESC)
                        seq_phase = tked_pkg::PH_ESC;
                    else if (ch == tked_pkg::CH_CR || ch == tked_pkg::CH_LF)
                        key = tked_pkg::KEY_ENTER;
                    else if (ch == tked_pkg::CH_TAB)
                        key = tked_pkg::KEY_TAB;
                    else if (ch == tked_pkg::CH_DEL || ch == tked_pkg::CH_BS)
                        key = tked_pkg::KEY_BKSP;
                    else
                        raw = 1'b1;
                end
            end
        endcase
        if (raw)
        begin
            ev.is_key = 1'b0;
            ev.value  = ch;
            pending_keys.push_back(ev);
        end
        else if (key != tked_pkg::KEY_NONE)
        begin
            ev.is_key = 1'b1;
            ev.value  = key;
            pending_keys.push_back(ev);
        end
    endfunction

    // Results are checked before the poll of the same edge is decoded, since a
    // result is registered in both the input and output stages after its poll.
    always @(posedge clk)
    begin : result_check
        key_event_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_keys.size() == 0)
            begin
                $error("unexpected result: is_key %0d value %0d",
                       result_ch.is_key, result_ch.value);
                error_count++;
            end
            else
            begin
                want = pending_keys.pop_front();
                if (result_ch.is_key !== want.is_key)
                begin
                    $error("is_key: expected %0d, actual %0d", want.is_key, result_ch.is_key);
                    error_count++;
                end
                if (result_ch.value !== want.value)
                begin
                    $error("value: expected %0d, actual %0d", want.value, result_ch.value);
                    error_count++;
                end
            end
        end
        if (rst_n && poll_ch.valid && poll_ch.ready)
            decode_poll(poll_ch.byte_present, poll_ch.in_byte);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_poll(input logic present, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            poll_ch.valid <= 1'b0;
        end
        @(negedge clk);
        poll_ch.valid        <= 1'b1;
        poll_ch.byte_present <= present;
        poll_ch.in_byte      <= ch;
        @(posedge clk);
        while (!poll_ch.ready)
            @(posedge clk);
        polls_sent++;
    endtask

    task automatic send_byte(input logic [7:0] ch);
        send_poll(1'b1, ch);
    endtask

    // The byte lines carry noise on an empty poll; the block must ignore them.
    task automatic send_empty();
        send_poll(1'b0, 8'($urandom_range(255)));
    endtask

    task automatic send_number(input int n);
        if (n >= 100)
            send_byte(tked_pkg::CH_ZERO + 8'(n / 100));
        if (n >= 10)
            send_byte(tked_pkg::CH_ZERO + 8'((n / 10) % 10));
        send_byte(tked_pkg::CH_ZERO + 8'(n % 10));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        poll_ch.valid <= 1'b0;
        while (pending_keys.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_csi_final();
        case ($urandom_range(9))
            0:       return tked_pkg::CH_A;
            1:       return tked_pkg::CH_B;
            2:       return tked_pkg::CH_C;
            3:       return tked_pkg::CH_D;
            4:       return tked_pkg::CH_H;
            5:       return tked_pkg::CH_F;
            6:       return tked_pkg::CH_Z;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_ss3_final();
        case ($urandom_range(7))
            0:       return tked_pkg::CH_P;
            1:       return tked_pkg::CH_Q;
            2:       return tked_pkg::CH_R;
            3:       return tked_pkg::CH_S;
            4:       return tked_pkg::CH_H;
            5:       return tked_pkg::CH_F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_plain_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(tked_pkg::CH_CR);
        send_byte(tked_pkg::CH_LF);
        send_byte(tked_pkg::CH_TAB);
        send_byte(tked_pkg::CH_DEL);
        send_byte(tked_pkg::CH_BS);
        send_empty();
    endtask

    task automatic test_escape_sequences();
        send_byte(tked_pkg::CH_ESC);
        send_empty();
        send_byte(tked_pkg::CH_ESC);
        send_byte(tked_pkg::CH_LBRACK);
        send_byte(tked_pkg::CH_A);
        send_byte(tked_pkg::CH_ESC);
        send_byte(tked_pkg::CH_LBRACK);
        send_number(24);
        send_byte(tked_pkg::CH_TILDE);
        send_byte(tked_pkg::CH_ESC);
        send_byte(tked_pkg::CH_LBRACK);
        send_number(3);
        send_byte(tked_pkg::CH_SEMI);
        send_byte(tked_pkg::CH_ZERO + 8'd5);
        send_byte(tked_pkg::CH_Z);
        send_byte(tked_pkg::CH_ESC);
        send_byte(tked_pkg::CH_SS3);
        send_byte(tked_pkg::CH_P);
        // The accumulator saturates, so this number maps to no key.
        send_byte(tked_pkg::CH_ESC);
        send_byte(tked_pkg::CH_LBRACK);
        send_number(999);
        send_byte(tked_pkg::CH_TILDE);
    endtask

    // The sender stops in the middle of a sequence until all results are in.
    task automatic test_pause_until_drained();
        send_byte(tked_pkg::CH_ESC);
        send_byte(tked_pkg::CH_LBRACK);
        wait_drained();
        send_byte(tked_pkg::CH_B);
        wait_drained();
    endtask

    task automatic test_random_keys(input int count, input int idle_pct, input int stall_pct);
        int start;
        int pick;
        int r;
        int k;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = polls_sent;
        while (polls_sent - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_byte(8'($urandom_range(255)));
            else if (pick < 37)
                send_empty();
            else if (pick < 44)
            begin
                send_byte(tked_pkg::CH_ESC);
                send_empty();
            end
            else if (pick < 58)
            begin
                send_byte(tked_pkg::CH_ESC);
                send_byte(tked_pkg::CH_LBRACK);
                if ($urandom_range(9) == 0)
                    send_empty();
                else
                    send_byte(pick_csi_final());
            end
            else if (pick < 76)
            begin
                send_byte(tked_pkg::CH_ESC);
                send_byte(tked_pkg::CH_LBRACK);
                send_number(($urandom_range(99) < 85) ? $urandom_range(25) : $urandom_range(999));
                r = $urandom_range(99);
                if (r < 80)
                    send_byte(tked_pkg::CH_TILDE);
                else if (r < 92)
                    send_byte(8'($urandom_range(255)));
                else
                    send_empty();
            end
            else if (pick < 87)
            begin
                send_byte(tked_pkg::CH_ESC);
                send_byte(tked_pkg::CH_LBRACK);
                send_number($urandom_range(30));
                send_byte(tked_pkg::CH_SEMI);
                r = $urandom_range(99);
                if (r < 60)
                    send_byte(tked_pkg::CH_ZERO + 8'($urandom_range(2, 8)));
                else if (r < 85)
                    send_byte(8'($urandom_range(255)));
                else
                    send_empty();
                r = $urandom_range(99);
                if (r < 80)
                    send_byte(tked_pkg::CH_Z);
                else if (r < 90)
                    send_byte(8'($urandom_range(255)));
                else
                    send_empty();
            end
            else if (pick < 96)
            begin
                send_byte(tked_pkg::CH_ESC);
                send_byte(tked_pkg::CH_SS3);
                if ($urandom_range(9) < 2)
                    send_empty();
                else
                    send_byte(pick_ss3_final());
            end
            else
            begin
                // Broken sequences: escape-heavy noise.
                for (k = $urandom_range(2, 6); k > 0; k--)
                begin
                    r = $urandom_range(9);
                    if (r < 3)
                        send_byte(tked_pkg::CH_ESC);
                    else if (r < 5)
                        send_byte(tked_pkg::CH_LBRACK);
                    else if (r < 6)
                        send_byte(tked_pkg::CH_SS3);
                    else if (r < 7)
                        send_empty();
                    else
                        send_byte(8'($urandom_range(255)));
                end
            end
        end
    endtask

    initial
    begin
        poll_ch.valid        = 1'b0;
        poll_ch.byte_present = 1'b0;
        poll_ch.in_byte      = 8'h00;
        result_ch.ready      = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_plain_bytes();
        test_escape_sequences();
        test_random_keys(130, 0, 0);
        test_random_keys(130, 79, 0);
        test_pause_until_drained();
        test_random_keys(130, 0, 79);
        test_random_keys(130, 14, 14);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
